FILE: hw/rtl/ovd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovd_pkg
// Shared types and constants for the overdrive soft/hard clip and mix unit.
// ----------------------------------------------------------------------------
package ovd_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 12;
	localparam int THR_W       = 15;
	localparam int SOFT_W      = 8;
	localparam int BAL_W       = 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 15;

	// gained value, Q.8, exact
	localparam int P_W         = 28;
	// |excess| * 16 with one spare top bit
	localparam int DIV_W       = 32;
	localparam int DIV_STEPS   = 4;
	localparam int DIV_STAGES  = DIV_W / DIV_STEPS;

	localparam logic [GAIN_W-1:0] GAIN_RST           = GAIN_W'(1024);
	localparam logic [THR_W-1:0]  THRESHOLD_SOFT_RST = THR_W'(28000);
	localparam logic [SOFT_W-1:0] SOFTENER_RST       = SOFT_W'(64);
	localparam logic [THR_W-1:0]  THRESHOLD_HARD_RST = THR_W'(32767);
	localparam logic [BAL_W-1:0]  WET_BALANCE_RST    = BAL_W'(256);
	localparam logic [BAL_W-1:0]  DRY_BALANCE_RST    = BAL_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN           = 3'd0,
		REG_THRESHOLD_SOFT = 3'd1,
		REG_SOFTENER       = 3'd2,
		REG_THRESHOLD_HARD = 3'd3,
		REG_WET_BALANCE    = 3'd4,
		REG_DRY_BALANCE    = 3'd5
	} ovd_reg_e;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [THR_W-1:0]  threshold_soft;
		logic [SOFT_W-1:0] softener;
		logic [THR_W-1:0]  threshold_hard;
		logic [BAL_W-1:0]  wet_balance;
		logic [BAL_W-1:0]  dry_balance;
	} ovd_cfg_t;

	// item context carried alongside the divider
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [P_W-1:0]      p;
		logic                       hi;
		logic                       lo;
	} ovd_side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ovd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovd_cfg_regs
// Configuration register file; indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module ovd_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ovd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ovd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ovd_pkg::ovd_cfg_t                      cfg
);

	ovd_pkg::ovd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain           <= ovd_pkg::GAIN_RST;
			cfg_q.threshold_soft <= ovd_pkg::THRESHOLD_SOFT_RST;
			cfg_q.softener       <= ovd_pkg::SOFTENER_RST;
			cfg_q.threshold_hard <= ovd_pkg::THRESHOLD_HARD_RST;
			cfg_q.wet_balance    <= ovd_pkg::WET_BALANCE_RST;
			cfg_q.dry_balance    <= ovd_pkg::DRY_BALANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (ovd_pkg::ovd_reg_e'(cfg_index))
				ovd_pkg::REG_GAIN: begin
					cfg_q.gain <= cfg_data[ovd_pkg::GAIN_W-1:0];
				end
				ovd_pkg::REG_THRESHOLD_SOFT: begin
					cfg_q.threshold_soft <= cfg_data[ovd_pkg::THR_W-1:0];
				end
				ovd_pkg::REG_SOFTENER: begin
					cfg_q.softener <= cfg_data[ovd_pkg::SOFT_W-1:0];
				end
				ovd_pkg::REG_THRESHOLD_HARD: begin
					cfg_q.threshold_hard <= cfg_data[ovd_pkg::THR_W-1:0];
				end
				ovd_pkg::REG_WET_BALANCE: begin
					cfg_q.wet_balance <= cfg_data[ovd_pkg::BAL_W-1:0];
				end
				ovd_pkg::REG_DRY_BALANCE: begin
					cfg_q.dry_balance <= cfg_data[ovd_pkg::BAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ovd_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovd_div_pipe
// Pipelined restoring divider, DIV_STEPS quotient bits per stage, elastic
// valid/ready with per-stage enables so bubbles collapse.
// ----------------------------------------------------------------------------
module ovd_div_pipe (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ovd_pkg::DIV_W-1:0]       dividend,
	input  wire logic [ovd_pkg::SOFT_W-1:0]      divisor,
	input  wire ovd_pkg::ovd_side_t              side_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [ovd_pkg::DIV_W-1:0]            quotient,
	output ovd_pkg::ovd_side_t                   side_out
);

	localparam int NS = ovd_pkg::DIV_STAGES;
	localparam int DW = ovd_pkg::DIV_W;
	localparam int RW = ovd_pkg::SOFT_W;

	typedef struct packed {
		logic [DW-1:0] num;
		logic [RW-1:0] rem;
	} div_st_t;

	function automatic div_st_t div_steps(div_st_t st, logic [RW-1:0] d);
		div_st_t     r;
		logic [RW:0] t;
		r = st;
		for (int i = 0; i < ovd_pkg::DIV_STEPS; i++) begin
			t = {r.rem, r.num[DW-1]};
			if (t >= {1'b0, d}) begin
				r.rem = RW'(t - {1'b0, d});
				r.num = {r.num[DW-2:0], 1'b1};
			end else begin
				r.rem = t[RW-1:0];
				r.num = {r.num[DW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic                        v_s   [NS];
	div_st_t                     st_s  [NS];
	logic [RW-1:0]               dvs_s [NS];
	ovd_pkg::ovd_side_t          side_s[NS];
	logic [NS-1:0]               en;

	always_comb begin
		en[NS-1] = !v_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[NS-1];
	assign quotient  = st_s[NS-1].num;
	assign side_out  = side_s[NS-1];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		if (k == 0) begin : g_first
			div_st_t st_in;
			assign st_in.num = dividend;
			assign st_in.rem = '0;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k] && in_valid) begin
					st_s[k]   <= div_steps(st_in, divisor);
					dvs_s[k]  <= divisor;
					side_s[k] <= side_in;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k] && v_s[k-1]) begin
					st_s[k]   <= div_steps(st_s[k-1], dvs_s[k-1]);
					dvs_s[k]  <= dvs_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NS-1] |-> (st_s[NS-1].rem < dvs_s[NS-1]))
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

FILE: hw/rtl/ovd_clip_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovd_clip_mix
// Soft-clip rebuild and hard clip, wet/dry products, then sum, truncate
// toward zero and saturate into the output register.
// ----------------------------------------------------------------------------
module ovd_clip_mix (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire ovd_pkg::ovd_cfg_t                      cfg,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [ovd_pkg::DIV_W-1:0]              quotient,
	input  wire ovd_pkg::ovd_side_t                     side_in,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [ovd_pkg::SAMPLE_W-1:0]         sample_out
);

	localparam int SW = 34;
	localparam int YW = 24;
	localparam int WYW = 33;
	localparam int DXW = 25;
	localparam int RW = SW - 16;

	localparam logic signed [RW-1:0] R_MAX = RW'(32767);
	localparam logic signed [RW-1:0] R_MIN = -RW'(32768);

	logic                           v_s1, v_s2, v_s3;
	logic                           en1, en2, en3;
	logic signed [YW-1:0]           y_s1;
	logic signed [ovd_pkg::SAMPLE_W-1:0] x_s1;
	logic signed [WYW-1:0]          wy_s2;
	logic signed [DXW-1:0]          dx_s2;
	logic signed [ovd_pkg::SAMPLE_W-1:0] out_s3;

	logic signed [SW-1:0] t8, qe, pe, soft_val, h8, lim_lo;
	logic signed [YW-1:0] y_nxt;
	logic signed [SW-1:0] wy_full;
	logic signed [25:0]   dx_full;
	logic signed [SW-1:0] acc, acc_adj;
	logic signed [RW-1:0] r;
	logic signed [ovd_pkg::SAMPLE_W-1:0] sat;
	logic signed [SW-1:0] y_chk;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// soft clip rebuild and hard clip
	always_comb begin
		t8     = $signed({11'd0, cfg.threshold_soft, 8'd0});
		qe     = $signed({2'd0, quotient});
		pe     = SW'(side_in.p);
		h8     = $signed({11'd0, cfg.threshold_hard, 8'd0});
		lim_lo = -$signed({10'd0, 16'({1'b0, cfg.threshold_hard} + 16'd1), 8'd0});
		if (side_in.hi) begin
			soft_val = t8 + qe;
		end else if (side_in.lo) begin
			soft_val = -t8 - qe;
		end else begin
			soft_val = pe;
		end
		if (soft_val > h8) begin
			y_nxt = h8[YW-1:0];
		end else if (soft_val < -h8) begin
			y_nxt = lim_lo[YW-1:0];
		end else begin
			y_nxt = soft_val[YW-1:0];
		end
	end

	assign wy_full = $signed({1'b0, cfg.wet_balance}) * y_s1;
	assign dx_full = $signed({1'b0, cfg.dry_balance}) * x_s1;

	always_comb begin
		acc     = SW'(wy_s2) + $signed({dx_s2[DXW-1], dx_s2, 8'd0});
		acc_adj = acc[SW-1] ? acc + SW'(65535) : acc;
		r       = acc_adj[SW-1:16];
		if (r > R_MAX) begin
			sat = ovd_pkg::SAMPLE_W'(R_MAX);
		end else if (r < R_MIN) begin
			sat = ovd_pkg::SAMPLE_W'(R_MIN);
		end else begin
			sat = r[ovd_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			y_s1 <= y_nxt;
			x_s1 <= side_in.x;
		end
		if (en2 && v_s1) begin
			wy_s2 <= wy_full[WYW-1:0];
			dx_s2 <= dx_full[DXW-1:0];
		end
		if (en3 && v_s2) begin
			out_s3 <= sat;
		end
	end

	assign out_valid  = v_s3;
	assign sample_out = out_s3;

	assign y_chk = SW'(y_s1);

	a_y_in_hard_limits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((y_chk <= h8) && (y_chk >= lim_lo)))
		else $error("clipped value outside hard limits");

endmodule
`default_nettype wire

FILE: hw/rtl/overdrive_soft_hard_clip_mix_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overdrive_soft_hard_clip_mix_unit
// Gain, soft clip with divided excess, hard clip, wet/dry mix, saturation.
// ----------------------------------------------------------------------------
// Pipeline: 13 register stages (gain multiply, soft-clip setup, 8 divider
//   stages at 4 quotient bits each, clip, mix products, sum/saturate output
//   register).
// Throughput: one item per cycle while out_ready is high; each stage advances
//   when the next is empty or moving, so bubbles collapse under output stall.
// Reset: clears all valid bits and loads register defaults; payload is not
//   reset.
// ----------------------------------------------------------------------------
module overdrive_soft_hard_clip_mix_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [ovd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [ovd_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [ovd_pkg::SAMPLE_W-1:0]    sample_in,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [ovd_pkg::SAMPLE_W-1:0]         sample_out
);

	localparam int PW = ovd_pkg::P_W;

	ovd_pkg::ovd_cfg_t cfg;

	logic                                v_s1, v_s2;
	logic                                en1, en2;
	logic signed [ovd_pkg::SAMPLE_W-1:0] x_s1;
	logic signed [PW-1:0]                p_s1;
	ovd_pkg::ovd_side_t                  side_s2;
	logic [ovd_pkg::DIV_W-1:0]           dvd_s2;
	logic [ovd_pkg::SOFT_W-1:0]          dvs_s2;

	logic signed [PW:0]                  prod;
	logic signed [PW:0]                  p_ext, t8, d_hi, d_lo;
	logic                                hi, lo;
	logic [PW-2:0]                       mag;
	logic [ovd_pkg::SOFT_W-1:0]          dvs;

	logic                                div_in_ready;
	logic                                div_out_valid;
	logic                                cm_in_ready;
	logic [ovd_pkg::DIV_W-1:0]           quotient;
	ovd_pkg::ovd_side_t                  div_side;

	ovd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en2      = !v_s2 || div_in_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign prod = sample_in * $signed({1'b0, cfg.gain});

	// soft-clip region and |excess| * 16
	always_comb begin
		p_ext = (PW + 1)'(p_s1);
		t8    = $signed({6'd0, cfg.threshold_soft, 8'd0});
		hi    = p_ext > t8;
		lo    = p_ext < -t8;
		d_hi  = p_ext - t8;
		d_lo  = -p_ext - t8;
		if (hi) begin
			mag = d_hi[PW-2:0];
		end else if (lo) begin
			mag = d_lo[PW-2:0];
		end else begin
			mag = '0;
		end
		dvs = (cfg.softener == '0) ? ovd_pkg::SOFT_W'(1) : cfg.softener;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			x_s1 <= sample_in;
			p_s1 <= prod[PW-1:0];
		end
		if (en2 && v_s1) begin
			side_s2.x  <= x_s1;
			side_s2.p  <= p_s1;
			side_s2.hi <= hi;
			side_s2.lo <= lo;
			dvd_s2     <= {1'b0, mag, 4'd0};
			dvs_s2     <= dvs;
		end
	end

	ovd_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.dividend  (dvd_s2),
		.divisor   (dvs_s2),
		.side_in   (side_s2),
		.out_valid (div_out_valid),
		.out_ready (cm_in_ready),
		.quotient  (quotient),
		.side_out  (div_side)
	);

	ovd_clip_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (div_out_valid),
		.in_ready   (cm_in_ready),
		.quotient   (quotient),
		.side_in    (div_side),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	a_region_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(side_s2.hi && side_s2.lo))
		else $error("item flagged both above and below soft threshold");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && !div_in_ready))
		else $error("input stalled with a free front stage");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (dvs_s2 != '0))
		else $error("zero divisor entered divider");

endmodule
`default_nettype wire
